// ===== rtl/xtea_pkg.sv =====
// Shared constants, stage payload type and round helpers for the XTEA cipher.
// Used by xtea_block_cipher; depends on nothing else.
package xtea_pkg;

  // Number of full rounds and of half-round pipeline stages.
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  // Key register file.
  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned WORD_W = 32;

  // Direction codes carried in tuser.
  localparam logic ACT_ENCIPHER = 1'b0;
  localparam logic ACT_DECIPHER = 1'b1;

  // Payload that travels down the half-round pipeline.
  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } stage_t;

  // Shift, xor and add mixing term of one half-round.
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    a = (x << 4) ^ (x >> 5);
    return a + x;
  endfunction

  // Running sum seen by half-round stage k, worked out at elaboration.
  // Enciphering counts up from zero, deciphering down from DELTA * ROUNDS.
  function automatic logic [WORD_W-1:0] stage_sum(input int unsigned k, input logic dec);
    int unsigned       rnd;
    int unsigned       cnt;
    logic [WORD_W-1:0] c;
    rnd = k >> 1;
    if (dec) begin
      cnt = ROUNDS - rnd - (k & 1);
    end else begin
      cnt = rnd + (k & 1);
    end
    c = WORD_W'(cnt);
    return DELTA * c;
  endfunction

endpackage

// ===== rtl/xtea_block_cipher.sv =====
// XTEA block cipher with a fully unrolled half-round pipeline.
// Depends on xtea_pkg for constants, the stage type and the round helpers.
//
// Usage:
//   The slave stream takes one 64-bit block per item: tdata holds the first
//   word in bits 31:0 and the second word in bits 63:32, tuser bit 0 picks
//   the direction (0 encipher, 1 decipher). The master stream returns one
//   result block per item in the same tdata layout.
//   The 128-bit key lives in four 32-bit registers written through the
//   cfg port (index 0..3); writes to other indexes are ignored. Change the
//   key only while no item is in flight.
//   Each pipeline stage performs one half-round, ending in the output
//   register. Throughput is one item per cycle while the receiver keeps up;
//   every stage has its own valid bit and a per-stage ready chain, so empty
//   stages fill in while the output waits.
//   When the receiver stalls, full stages hold their items and tready drops
//   only once every stage is occupied; nothing is lost or repeated.
//   Reset clears all valid bits and sets the key registers to zero.
module xtea_block_cipher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [63:0]                         s_axis_tdata,  // first_word, second_word
  input  logic [0:0]                          s_axis_tuser,  // action
  // Master stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [63:0]                         m_axis_tdata,  // out_first_word, out_second_word
  // Key register write port.
  input  logic                                cfg_we_i,
  input  logic [xtea_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [xtea_pkg::WORD_W-1:0]         cfg_wdata_i
);
  import xtea_pkg::*;

  logic [KEY_COUNT-1:0][WORD_W-1:0] key_q;
  logic [STAGES-1:0]                vld_q;
  stage_t                           dat_q [STAGES];
  logic [STAGES:0]                  rdy;
  stage_t                           in_item;

  // Key registers: writes beyond the key file are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i && (cfg_addr_i < CFG_ADDR_W'(KEY_COUNT))) begin
      key_q[cfg_addr_i[1:0]] <= cfg_wdata_i;
    end
  end

  // Unpack the incoming item.
  assign in_item.action = s_axis_tuser[0];
  assign in_item.v0     = s_axis_tdata[31:0];
  assign in_item.v1     = s_axis_tdata[63:32];

  // Ready chain: a stage can load when it is empty or its item moves on.
  assign rdy[STAGES] = m_axis_tready;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [WORD_W-1:0] EncSum = stage_sum(k, ACT_ENCIPHER);
    localparam logic [WORD_W-1:0] DecSum = stage_sum(k, ACT_DECIPHER);
    localparam logic              Odd    = ((k % 2) == 1);

    stage_t            in_s;
    stage_t            out_s;
    logic              in_vld;
    logic              upd_v0;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] res;
    logic [1:0]        kidx;

    if (k == 0) begin : g_head
      assign in_s   = in_item;
      assign in_vld = s_axis_tvalid;
    end else begin : g_body
      assign in_s   = dat_q[k-1];
      assign in_vld = vld_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    // One half-round. Enciphering updates v0 on even stages and v1 on odd
    // ones; deciphering walks the same steps backwards, so the roles swap.
    always_comb begin
      upd_v0 = (in_s.action == Odd);
      sum    = (in_s.action == ACT_DECIPHER) ? DecSum : EncSum;
      src    = upd_v0 ? in_s.v1 : in_s.v0;
      dst    = upd_v0 ? in_s.v0 : in_s.v1;
      kidx   = upd_v0 ? sum[1:0] : sum[12:11];
      f      = mix(src) ^ (sum + key_q[kidx]);
      res    = (in_s.action == ACT_DECIPHER) ? (dst - f) : (dst + f);
      out_s  = in_s;
      if (upd_v0) begin
        out_s.v0 = res;
      end else begin
        out_s.v1 = res;
      end
    end

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= in_vld;
      end
    end

    // Stage payload.
    always_ff @(posedge clk_i) begin
      if (rdy[k] && in_vld) begin
        dat_q[k] <= out_s;
      end
    end
  end

  // Stream handshakes and result packing.
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = {dat_q[STAGES-1].v1, dat_q[STAGES-1].v0};

`ifndef SYNTHESIS
  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item did not reach the first stage");

  // A blocked first stage keeps its item unchanged.
  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !rdy[0]) |=> (vld_q[0] && $stable(dat_q[0])))
    else $error("first stage lost or changed a blocked item");

  // With the output register empty the whole pipeline can advance.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[STAGES-1] |-> s_axis_tready)
    else $error("input stalled although the output stage is empty");

  // Writes outside the key file leave the key untouched.
  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_addr_i >= CFG_ADDR_W'(KEY_COUNT))) |=> $stable(key_q))
    else $error("write to an unused index changed the key");
`endif

endmodule

// ===== tb/tb_xtea_block_cipher.sv =====
// Self-checking testbench for xtea_block_cipher: directed and random blocks under several keys.
// Each result is checked against an XTEA predictor of its own. Depends on xtea_pkg and the RTL.
typedef struct packed {
  logic [31:0] second_word;
  logic [31:0] first_word;
} block_t;

// Keeps a copy of the key, predicts each accepted block and holds the results still due.
class xtea_block_ledger;
  localparam int MAX_REPORTS = 10;

  logic [31:0] key_words [xtea_pkg::KEY_COUNT];
  block_t      blocks_due [$];
  int          mismatches;

  function new();
    foreach (key_words[i]) key_words[i] = '0;
    mismatches = 0;
  endfunction

  // Writes to indexes past the key file are dropped, as in the block.
  function void set_key(int unsigned idx, logic [31:0] val);
    if (idx < xtea_pkg::KEY_COUNT) key_words[idx] = val;
  endfunction

  function logic [31:0] shuffle(logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function block_t encipher(block_t blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    v0  = blk.first_word;
    v1  = blk.second_word;
    sum = '0;
    for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
      v0  = v0 + (shuffle(v1) ^ (sum + key_words[sum[1:0]]));
      sum = sum + xtea_pkg::DELTA;
      v1  = v1 + (shuffle(v0) ^ (sum + key_words[sum[12:11]]));
    end
    return '{second_word: v1, first_word: v0};
  endfunction

  // Deciphering walks the sum down from delta times the round count.
  function block_t decipher(block_t blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    v0  = blk.first_word;
    v1  = blk.second_word;
    sum = xtea_pkg::DELTA * 32'(xtea_pkg::ROUNDS);
    for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
      v1  = v1 - (shuffle(v0) ^ (sum + key_words[sum[12:11]]));
      sum = sum - xtea_pkg::DELTA;
      v0  = v0 - (shuffle(v1) ^ (sum + key_words[sum[1:0]]));
    end
    return '{second_word: v1, first_word: v0};
  endfunction

  function block_t note_block(logic act, block_t blk);
    block_t res;
    res = (act == xtea_pkg::ACT_DECIPHER) ? decipher(blk) : encipher(blk);
    blocks_due.push_back(res);
    return res;
  endfunction

  function void check_block(block_t got);
    block_t want;
    if (blocks_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected result block %h_%h", $realtime,
                 got.second_word, got.first_word);
      return;
    end
    want = blocks_due.pop_front();
    if (got.first_word !== want.first_word || got.second_word !== want.second_word) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] mismatch: out_first_word exp %h got %h, out_second_word exp %h got %h",
                 $realtime, want.first_word, got.first_word,
                 want.second_word, got.second_word);
    end
  endfunction

  function int pending();
    return blocks_due.size();
  endfunction
endclass

module tb_xtea_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  localparam realtime CLK_PERIOD   = 12ns;
  localparam int      RESET_CYCLES = 4;
  localparam int      IDLE_PERCENT = 7;
  localparam int      PHASE_ITEMS  = 305;
  localparam int      POOL_DEPTH   = 64;
  localparam int      LIMIT_CYCLES = 200000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;  // first_word, second_word
  logic [0:0]            s_axis_tuser  = '0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;        // out_first_word, out_second_word
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [WORD_W-1:0]     cfg_wdata_i   = '0;

  // When set, neither side inserts idle cycles.
  logic                  no_idle       = 1'b0;
  int unsigned           cycles        = 0;

  xtea_block_ledger ledger = new();
  block_t           cipher_pool [$];

  xtea_block_cipher i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver: stalls now and then unless the no-idle stretch is on.
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_block(m_axis_tdata);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("xtea_block_cipher regression: fail");
      $finish;
    end
  end

  task automatic write_key(input int unsigned idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_ADDR_W'(idx);
    cfg_wdata_i <= val;
    @(posedge clk_i);
    ledger.set_key(idx, val);
  endtask

  // Loads all four key words, then hits every unused index with junk.
  task automatic load_key(input logic [127:0] key128);
    for (int i = 0; i < KEY_COUNT; i++) write_key(i, key128[32*i +: 32]);
    for (int i = KEY_COUNT; i < (1 << CFG_ADDR_W); i++) write_key(i, $urandom);
    cfg_we_i <= 1'b0;
    cipher_pool.delete();
  endtask

  // Offers one item, with random idle cycles in front, and waits for acceptance.
  task automatic send_block(input logic act, input block_t blk, output block_t res);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = ledger.note_block(act, blk);
  endtask

  // Holds the sender until every expected result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      3:       return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // Field extremes in both directions, then a round trip of the first block.
  task automatic directed_blocks();
    block_t res;
    block_t first_cipher;
    send_block(ACT_ENCIPHER, '{32'h0, 32'h0}, first_cipher);
    send_block(ACT_DECIPHER, '{32'h0, 32'h0}, res);
    send_block(ACT_ENCIPHER, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, res);
    send_block(ACT_DECIPHER, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, res);
    send_block(ACT_ENCIPHER, '{32'hFFFF_FFFF, 32'h0}, res);
    send_block(ACT_DECIPHER, '{32'h0, 32'hFFFF_FFFF}, res);
    send_block(ACT_ENCIPHER, '{32'hAAAA_AAAA, 32'h5555_5555}, res);
    send_block(ACT_DECIPHER, '{32'h5555_5555, 32'hAAAA_AAAA}, res);
    send_block(ACT_ENCIPHER, '{32'h0000_0001, 32'h8000_0000}, res);
    send_block(ACT_DECIPHER, '{32'h8000_0000, 32'h0000_0001}, res);
    send_block(ACT_DECIPHER, first_cipher, res);
  endtask

  // Mostly encipher/decipher round trips of random blocks, mixed with loose blocks.
  task automatic random_blocks(input int count);
    block_t blk;
    block_t res;
    logic   act;
    for (int n = 0; n < count; n++) begin
      if (cipher_pool.size() != 0 && $urandom_range(2) == 0) begin
        act = ACT_DECIPHER;
        blk = cipher_pool.pop_front();
      end else begin
        act = 1'($urandom_range(1));
        blk = '{rand_word(), rand_word()};
      end
      send_block(act, blk, res);
      if (act == ACT_ENCIPHER && cipher_pool.size() < POOL_DEPTH) cipher_pool.push_back(res);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed blocks under the reset key and under an all-ones key.
    directed_blocks();
    drain();
    load_key('1);
    directed_blocks();
    drain();

    // Random blocks under a series of keys.
    load_key({$urandom, $urandom, $urandom, $urandom});
    random_blocks(PHASE_ITEMS);
    drain();
    load_key({4{32'hAAAA_AAAA}} ^ {64'h0, {2{32'hFFFF_FFFF}}});
    random_blocks(PHASE_ITEMS);
    drain();

    // Back-to-back stretch with no idle cycles on either side.
    no_idle <= 1'b1;
    load_key({$urandom, $urandom, $urandom, $urandom});
    random_blocks(PHASE_ITEMS);
    drain();
    no_idle <= 1'b0;

    load_key('0);
    random_blocks(PHASE_ITEMS);
    drain();
    load_key({rand_word(), rand_word(), rand_word(), rand_word()});
    random_blocks(PHASE_ITEMS);
    drain();
    load_key({32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0});
    random_blocks(PHASE_ITEMS);
    drain();

    // Give any stray result time to show up.
    repeat (2 * STAGES + 8) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("xtea_block_cipher regression: pass");
    end else begin
      $display("xtea_block_cipher regression: fail");
    end
    $finish;
  end

endmodule

// ===== xtea_block_cipher.f =====
rtl/xtea_pkg.sv
rtl/xtea_block_cipher.sv
tb/tb_xtea_block_cipher.sv
